// ----- hdl/i2da_pkg.sv -----
// ----------------------------------------------------------------------------
// i2da_pkg
// shared types and character constants for the integer to decimal text unit
// ----------------------------------------------------------------------------
package i2da_pkg;

   localparam int CHAR_WIDTH  = 7;
   localparam int DIGIT_WIDTH = 4;

   // ascii codes
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'd45;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 7'd57;

   // shift-add-three correction
   localparam logic [DIGIT_WIDTH-1:0] BCD_ADJ_LIMIT = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] BCD_ADJ       = 4'd3;

   // status of the binary to bcd converter
   typedef struct packed {
      logic busy;
      logic done;
   } dab_status_type;

endpackage

// ----- hdl/i2da_dabble.sv -----
// ----------------------------------------------------------------------------
// i2da_dabble
// iterative binary to bcd converter, one shift-add-three step per cycle
// ----------------------------------------------------------------------------
module i2da_dabble #(
   parameter int VALUE_WIDTH = 32,
   parameter int NUM_DIGITS  = 10
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       load,
   input  logic [VALUE_WIDTH-1:0]                     magnitude,
   output i2da_pkg::dab_status_type                   status,
   output logic [NUM_DIGITS*i2da_pkg::DIGIT_WIDTH-1:0] digits
);

   localparam int DW    = i2da_pkg::DIGIT_WIDTH;
   localparam int BCD_W = NUM_DIGITS * DW;
   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   // add three to every digit of five or more, all digits in parallel
   for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_adj
      assign bcd_adj[k*DW +: DW] = (bcd_ff[k*DW +: DW] >= i2da_pkg::BCD_ADJ_LIMIT) ?
                                   bcd_ff[k*DW +: DW] + i2da_pkg::BCD_ADJ :
                                   bcd_ff[k*DW +: DW];
   end

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (load) begin
         mag_in  = magnitude;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_ONE;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign digits      = bcd_ff;

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("converter done held for more than one cycle");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("converter done without a finished run");

endmodule

// ----- hdl/i2da_emit.sv -----
// ----------------------------------------------------------------------------
// i2da_emit
// character sequencer: drops leading zeros, sends sign and digits one by one
// ----------------------------------------------------------------------------
module i2da_emit #(
   parameter int NUM_DIGITS = 10
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic                                        negative,
   input  logic [NUM_DIGITS*i2da_pkg::DIGIT_WIDTH-1:0] digits,
   output logic                                        busy,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [i2da_pkg::CHAR_WIDTH-1:0]             rsp_char_code,
   output logic                                        rsp_last
);

   localparam int DW     = i2da_pkg::DIGIT_WIDTH;
   localparam int BCD_W  = NUM_DIGITS * DW;
   localparam int LEFT_W = $clog2(NUM_DIGITS + 1);
   localparam logic [LEFT_W-1:0] LEFT_ONE = LEFT_W'(1);
   localparam logic [LEFT_W-1:0] LEFT_ALL = LEFT_W'(NUM_DIGITS);

   localparam logic [1:0] E_IDLE  = 2'd0;
   localparam logic [1:0] E_SKIP  = 2'd1;
   localparam logic [1:0] E_SIGN  = 2'd2;
   localparam logic [1:0] E_DIGIT = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [BCD_W-1:0]                dig_ff, dig_in;
   logic [LEFT_W-1:0]               left_ff, left_in;
   logic                            neg_ff, neg_in;
   logic                            valid_ff, valid_in;
   logic [i2da_pkg::CHAR_WIDTH-1:0] char_ff, char_in;
   logic                            last_ff, last_in;
   logic [DW-1:0]                   top_digit;
   logic                            load_ok;

   assign top_digit = dig_ff[BCD_W-1 -: DW];
   assign load_ok   = !valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      dig_in   = dig_ff;
      left_in  = left_ff;
      neg_in   = neg_ff;
      valid_in = valid_ff && !rsp_ready;
      char_in  = char_ff;
      last_in  = last_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               dig_in   = digits;
               left_in  = LEFT_ALL;
               neg_in   = negative;
               state_in = E_SKIP;
            end
         end
         E_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top_digit == '0 && left_ff != LEFT_ONE) begin
               dig_in  = {dig_ff[BCD_W-DW-1:0], {DW{1'b0}}};
               left_in = left_ff - LEFT_ONE;
            end else begin
               state_in = neg_ff ? E_SIGN : E_DIGIT;
            end
         end
         E_SIGN: begin
            if (load_ok) begin
               valid_in = 1'b1;
               char_in  = i2da_pkg::CHAR_MINUS;
               last_in  = 1'b0;
               state_in = E_DIGIT;
            end
         end
         E_DIGIT: begin
            if (load_ok) begin
               valid_in = 1'b1;
               char_in  = i2da_pkg::CHAR_ZERO + {{(i2da_pkg::CHAR_WIDTH-DW){1'b0}}, top_digit};
               last_in  = (left_ff == LEFT_ONE);
               dig_in   = {dig_ff[BCD_W-DW-1:0], {DW{1'b0}}};
               left_in  = left_ff - LEFT_ONE;
               if (left_ff == LEFT_ONE) begin
                  state_in = E_IDLE;
               end
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dig_ff  <= dig_in;
      left_ff <= left_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (reset) begin
         state_ff <= E_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy          = (state_ff != E_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && char_ff == i2da_pkg::CHAR_MINUS |-> !last_ff)
      else $error("minus sign flagged as last character");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> char_ff == i2da_pkg::CHAR_MINUS ||
                   (char_ff >= i2da_pkg::CHAR_ZERO && char_ff <= i2da_pkg::CHAR_NINE))
      else $error("character is neither a digit nor a minus sign");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == E_DIGIT && load_ok && left_ff == LEFT_ONE |=>
      state_ff == E_IDLE && valid_ff && last_ff)
      else $error("final digit did not close the run");

endmodule

// ----- hdl/int_to_decimal_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_unit
// signed binary integer to decimal ascii text, one character per response
// ----------------------------------------------------------------------------
// usage
//   req_*  : one request carries a two's complement value of VALUE_WIDTH bits
//   rsp_*  : the text comes back one character per response: a '-' for a
//            negative value, then the digits most significant first with no
//            leading zeros; zero gives the single character '0'; rsp_last
//            marks the final character of each number
//   flow   : the bcd converter runs one shift-add-three step per cycle on a
//            shared adjust/shift unit; the sequencer then drops the leading
//            zeros and sends the sign, if any, and then the digits, one
//            character at a time
//   rate   : one request at a time; req_ready stays low from acceptance until
//            the last character has been placed in the output register
//   stall  : the output register holds a character until rsp_ready; the
//            sequencer waits meanwhile, and the next request can be taken
//            while the final character is still waiting
//   reset  : synchronous, active high; clears the sequencer and the output
//            valid, so nothing is pending afterwards
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [VALUE_WIDTH-1:0]   req_value,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [i2da_pkg::CHAR_WIDTH-1:0] rsp_char_code,
   output logic                            rsp_last
);

   // enough decimal digits for a magnitude of 2^(VALUE_WIDTH-1)
   localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_W      = NUM_DIGITS * i2da_pkg::DIGIT_WIDTH;

   i2da_pkg::dab_status_type dab_status;
   logic [BCD_W-1:0]         bcd_digits;
   logic [VALUE_WIDTH-1:0]   magnitude;
   logic                     req_accept;
   logic                     emit_busy;
   logic                     neg_ff, neg_in;

   // magnitude taken as unsigned, so the most negative value survives
   assign magnitude = req_value[VALUE_WIDTH-1] ? (~req_value + VALUE_WIDTH'(1)) : req_value;

   // idle only when neither the converter nor the sequencer holds work
   assign req_ready  = !dab_status.busy && !dab_status.done && !emit_busy;
   assign req_accept = req_valid && req_ready;

   // sign kept aside while the converter runs
   assign neg_in = req_accept ? req_value[VALUE_WIDTH-1] : neg_ff;

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
   end

   i2da_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS)
   ) u_dabble (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .magnitude (magnitude),
      .status    (dab_status),
      .digits    (bcd_digits)
   );

   i2da_emit #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .start         (dab_status.done),
      .negative      (neg_ff),
      .digits        (bcd_digits),
      .busy          (emit_busy),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ready && dab_status.busy)
      else $error("request accepted but converter not started");

endmodule
